@@ sv/page_buffer_pool_lru_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the page buffer pool core
// Shared concurrent assertion forms, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef PAGE_BUFFER_POOL_LRU_CORE_ASSERT_SVH
`define PAGE_BUFFER_POOL_LRU_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PBPL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PBPL_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/pbpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Page buffer pool package
// Request kinds and status codes of the page buffer pool core.
// ----------------------------------------------------------------------------
package pbpl_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [2:0] status_t;

	localparam kind_t KIND_FETCH = 2'd0;
	localparam kind_t KIND_NEW   = 2'd1;
	localparam kind_t KIND_UNPIN = 2'd2;
	localparam kind_t KIND_FLUSH = 2'd3;

	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_NOT_FOUND   = 3'd1;
	localparam status_t ST_ALL_PINNED  = 3'd2;
	localparam status_t ST_WRITE_FAIL  = 3'd3;
	localparam status_t ST_DISK_FAIL   = 3'd4;
	localparam status_t ST_NOT_PINNED  = 3'd5;
	localparam status_t ST_PIN_OVERFLOW = 3'd6;

endpackage

@@ sv/pbpl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pbpl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/page_buffer_pool_lru_core.sv @@
// A request is taken in IDLE, then scans the page-id RAM in SCAN and LAST, one
// slot per cycle through its single read port, and completes in EXEC.
// A new request is taken only once the last has left EXEC; a waiting result does not
// block acceptance of the next request, which then holds in its execute step.
// Reset (arst_n low) empties the pool: all slots free, nothing mapped or
// pinned, LRU list empty.
// ----------------------------------------------------------------------------
// Page buffer pool LRU core
// Page-id map, pin counts, dirty bits, free slots and LRU order of a pool.
// ----------------------------------------------------------------------------
`include "page_buffer_pool_lru_core_assert.svh"

module page_buffer_pool_lru_core #(
	parameter int POOL_SLOTS   = 16,
	parameter int PIN_BITS     = 8,
	parameter int PAGE_ID_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// page_id, mark_dirty, write_ok, read_ok, alloc_ok, zero fill
	input  logic [((PAGE_ID_BITS + 4 + 7) / 8) * 8 - 1:0] s_tdata,
	// kind
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// status, slot, hit, load_from_disk, evicted, writeback, victim_page_id, zero fill
	output logic [((PAGE_ID_BITS + ((POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1) + 7 + 7) / 8)
		* 8 - 1:0] m_tdata
);

	localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int LW = $clog2(POOL_SLOTS + 1);
	localparam int P  = PAGE_ID_BITS;
	localparam int OW = ((P + SW + 7 + 7) / 8) * 8;
	localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_SLOTS - 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
	localparam logic [LW-1:0] FULL = LW'(POOL_SLOTS);

	typedef enum logic [1:0] {IDLE, SCAN, LAST, EXEC} state_t;

	state_t state_q;
	logic [SW-1:0] rd_q, addr_s1;
	logic          vld_s1;
	logic [P-1:0]  rdata;

	// request
	pbpl_pkg::kind_t kind_q;
	logic [P-1:0] pid_q;
	logic mdirty_q, wok_q, rok_q, aok_q;
	logic found_q;
	logic [SW-1:0] f_q;
	logic [P-1:0] vid_q;
	logic          vdup_hit_q;
	logic [SW-1:0] vdup_q;

	// per-slot state
	logic [POOL_SLOTS-1:0] mapped_q, dirty_q, in_lru_q;
	logic [PIN_BITS-1:0] pin_q [POOL_SLOTS];
	logic [SW-1:0] rank_q [POOL_SLOTS];
	logic [LW-1:0] lru_len_q, free_top_q;

	// victim: listed slot at the least recent position
	logic [SW-1:0] victim;
	always_comb begin
		victim = '0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			if (in_lru_q[i] && rank_q[i] == '0) begin
				victim = SW'(i);
			end
		end
	end

	// decisions of the execute cycle
	pbpl_pkg::status_t st;
	logic [SW-1:0] slot;
	logic hit, load, ev, wb;
	logic [P-1:0] vid;
	logic map_en, unmap_f, pin_en, dirty_en, dirty_val, ftop_dec, remap_v;
	logic [PIN_BITS-1:0] pin_val;
	logic [SW-1:0] pin_slot, dirty_slot;
	logic rm_en, ins_en;
	logic [SW-1:0] rm_slot, ins_slot;
	logic from_free, disk_ok;

	always_comb begin
		st = pbpl_pkg::ST_OK;
		slot = '0;
		hit = 1'b0;
		load = 1'b0;
		ev = 1'b0;
		wb = 1'b0;
		vid = '0;
		map_en = 1'b0;
		unmap_f = 1'b0;
		remap_v = 1'b0;
		pin_en = 1'b0;
		pin_val = '0;
		pin_slot = f_q;
		dirty_en = 1'b0;
		dirty_val = 1'b0;
		dirty_slot = f_q;
		ftop_dec = 1'b0;
		rm_en = 1'b0;
		rm_slot = f_q;
		ins_en = 1'b0;
		ins_slot = f_q;
		from_free = free_top_q != '0;
		disk_ok = (kind_q == pbpl_pkg::KIND_FETCH) ? rok_q : aok_q;
		if (kind_q == pbpl_pkg::KIND_FETCH && found_q) begin
			if (pin_q[f_q] == PIN_MAX) begin
				st = pbpl_pkg::ST_PIN_OVERFLOW;
			end else begin
				pin_en = 1'b1;
				pin_val = pin_q[f_q] + 1'b1;
				rm_en = in_lru_q[f_q];
				slot = f_q;
				hit = 1'b1;
			end
		end else if (kind_q == pbpl_pkg::KIND_FETCH || kind_q == pbpl_pkg::KIND_NEW) begin
			if (from_free) begin
				slot = SW'(free_top_q - 1'b1);
			end else if (lru_len_q == '0) begin
				st = pbpl_pkg::ST_ALL_PINNED;
			end else begin
				slot = victim;
				rm_en = 1'b1;
				rm_slot = victim;
				ins_slot = victim;
				vid = vid_q;
				if (dirty_q[victim]) begin
					wb = 1'b1;
					if (!wok_q) begin
						ins_en = 1'b1;
						st = pbpl_pkg::ST_WRITE_FAIL;
					end
				end
				if (st == pbpl_pkg::ST_OK) begin
					ev = 1'b1;
				end
			end
			if (st == pbpl_pkg::ST_OK && !disk_ok) begin
				// Roll back: a free slot stays free, a victim goes back to the list.
				if (ev) begin
					ins_en = 1'b1;
					remap_v = 1'b1;
					ev = 1'b0;
					if (wb) begin
						dirty_en = 1'b1;
						dirty_slot = victim;
						dirty_val = 1'b0;
					end
				end
				st = pbpl_pkg::ST_DISK_FAIL;
			end
			if (st == pbpl_pkg::ST_OK) begin
				map_en = 1'b1;
				unmap_f = found_q && (f_q != slot);
				pin_en = 1'b1;
				pin_slot = slot;
				pin_val = PIN_BITS'(1);
				dirty_en = 1'b1;
				dirty_slot = slot;
				dirty_val = 1'b0;
				load = kind_q == pbpl_pkg::KIND_FETCH;
				ftop_dec = from_free;
			end else begin
				slot = '0;
			end
		end else if (!found_q) begin
			st = pbpl_pkg::ST_NOT_FOUND;
		end else if (kind_q == pbpl_pkg::KIND_UNPIN) begin
			if (pin_q[f_q] == '0) begin
				st = pbpl_pkg::ST_NOT_PINNED;
			end else begin
				pin_en = 1'b1;
				pin_val = pin_q[f_q] - 1'b1;
				if (mdirty_q) begin
					dirty_en = 1'b1;
					dirty_val = 1'b1;
				end
				ins_en = (pin_val == '0) && !in_lru_q[f_q];
				slot = f_q;
			end
		end else begin
			if (dirty_q[f_q]) begin
				wb = 1'b1;
				vid = pid_q;
				if (wok_q) begin
					dirty_en = 1'b1;
					dirty_val = 1'b0;
				end else begin
					st = pbpl_pkg::ST_WRITE_FAIL;
				end
			end
			if (st == pbpl_pkg::ST_OK) begin
				slot = f_q;
			end
		end
		if (!ev && !wb) begin
			vid = '0;
		end
	end

	logic fire;
	logic [SW-1:0] rm_rank;
	logic [LW-1:0] len_after_rm;
	logic [SW-1:0] rd_addr;
	assign fire = (state_q == EXEC) && (!m_tvalid || m_tready);
	assign rm_rank = rank_q[rm_slot];
	assign len_after_rm = lru_len_q - LW'(rm_en);
	assign s_tready = state_q == IDLE;
	// While idle the RAM reads the victim's page id, so the scan can look for
	// another slot mapped to it.
	assign rd_addr = (state_q == IDLE) ? victim : rd_q;

	pbpl_ram #(.WIDTH(P), .DEPTH(POOL_SLOTS)) u_page_ram (
		.clk   (clk),
		.we    (fire && map_en),
		.waddr (slot),
		.wdata (pid_q),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rd_q <= '0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			vdup_hit_q <= 1'b0;
			m_tvalid <= 1'b0;
			mapped_q <= '0;
			dirty_q <= '0;
			in_lru_q <= '0;
			lru_len_q <= '0;
			free_top_q <= FULL;
			for (int i = 0; i < POOL_SLOTS; i++) begin
				pin_q[i] <= '0;
			end
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			vld_s1 <= 1'b0;
			addr_s1 <= rd_q;
			if (state_q == SCAN && rd_q == '0) begin
				vid_q <= rdata;
			end
			if (vld_s1) begin
				if (mapped_q[addr_s1] && rdata == pid_q) begin
					found_q <= 1'b1;
					f_q <= addr_s1;
				end
				if (mapped_q[addr_s1] && rdata == vid_q && addr_s1 != victim) begin
					vdup_hit_q <= 1'b1;
					vdup_q <= addr_s1;
				end
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						kind_q <= s_tuser;
						pid_q <= s_tdata[P-1:0];
						mdirty_q <= s_tdata[P];
						wok_q <= s_tdata[P+1];
						rok_q <= s_tdata[P+2];
						aok_q <= s_tdata[P+3];
						found_q <= 1'b0;
						vdup_hit_q <= 1'b0;
						rd_q <= '0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					vld_s1 <= 1'b1;
					if (rd_q == LAST_SLOT) begin
						state_q <= LAST;
					end else begin
						rd_q <= rd_q + 1'b1;
					end
				end
				LAST: begin
					state_q <= EXEC;
				end
				EXEC: begin
					if (fire) begin
						m_tvalid <= 1'b1;
						m_tdata <= OW'({vid, wb, ev, load, hit, slot, st});
						if (map_en) begin
							mapped_q[slot] <= 1'b1;
						end
						if (unmap_f) begin
							mapped_q[f_q] <= 1'b0;
						end
						// A rolled back victim takes its page id back from any other slot.
						if (remap_v) begin
							mapped_q[victim] <= 1'b1;
							if (vdup_hit_q) begin
								mapped_q[vdup_q] <= 1'b0;
							end
						end
						if (pin_en) begin
							pin_q[pin_slot] <= pin_val;
						end
						if (dirty_en) begin
							dirty_q[dirty_slot] <= dirty_val;
						end
						if (ftop_dec) begin
							free_top_q <= free_top_q - 1'b1;
						end
						// Removal closes the gap; insertion appends at the most recent end.
						for (int i = 0; i < POOL_SLOTS; i++) begin
							if (rm_en && in_lru_q[i] && rank_q[i] > rm_rank) begin
								rank_q[i] <= rank_q[i] - 1'b1;
							end
						end
						if (rm_en) begin
							in_lru_q[rm_slot] <= 1'b0;
						end
						if (ins_en) begin
							in_lru_q[ins_slot] <= 1'b1;
							rank_q[ins_slot] <= SW'(len_after_rm);
							lru_len_q <= len_after_rm + 1'b1;
						end else begin
							lru_len_q <= len_after_rm;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	logic [POOL_SLOTS-1:0] pinned;
	always_comb begin
		for (int i = 0; i < POOL_SLOTS; i++) begin
			pinned[i] = pin_q[i] != '0;
		end
	end

	`PBPL_ASSERT(a_lru_len, $countones(in_lru_q) == lru_len_q, "LRU length out of step")
	`PBPL_ASSERT_NEVER(a_pinned_listed, (pinned & in_lru_q) != '0, "pinned slot in LRU list")
	`PBPL_ASSERT(a_out_from_exec, $rose(m_tvalid) |-> $past(state_q == EXEC), "stray result")
	`PBPL_ASSERT(a_free_bound, free_top_q <= FULL, "free count above pool size")

endmodule
